@@ sv/c2p_pkg.sv @@
// Shared constants, types and the arctangent table for the cartesian_to_polar block.
// No dependencies; every module of the block imports it.
package c2p_pkg;

  localparam int CORDIC_STEPS  = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int ATAN_IDX_W    = $clog2(ATAN_ENTRIES);
  localparam int CORDIC_ITER   = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int SQRT_STEPS    = 16;
  localparam int PIPE_STEPS    = (CORDIC_ITER > SQRT_STEPS) ? CORDIC_ITER : SQRT_STEPS;
  localparam int PREP_STAGES   = 3;
  localparam int LATENCY       = PREP_STAGES + PIPE_STEPS + 1;

  localparam int COORD_W       = 16;
  localparam int RADIUS_W      = 16;
  localparam int ANGLE_W       = 17;
  localparam int ROT_W         = COORD_W + 1;
  localparam int FRAC_SHIFT    = 24;
  localparam int CW            = 43;
  localparam int ZW            = 26;
  localparam int SQ_W          = 32;
  localparam int SQ_TW         = 34;
  localparam int ROOT_W        = 16;
  localparam int ANGLE_SHIFT   = 8;

  localparam logic signed [ZW-1:0] DEG90_FIX  = ZW'(5898240);
  localparam logic signed [ZW-1:0] ANGLE_RND  = ZW'(128);
  localparam logic signed [ZW-1:0] ANGLE_MAX  = ZW'(46080);
  localparam logic signed [ANGLE_W-1:0] ANGLE_LIM = ANGLE_W'(46080);

  typedef struct packed {
    logic y_zero;
    logic x_neg;
  } c2p_flags_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } c2p_vec_t;

  typedef struct packed {
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
  } c2p_root_t;

  // atan(2^-i) in degrees * 2^16
  function automatic logic signed [ZW-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      ATAN_IDX_W'(0):  v = ZW'(2949120);
      ATAN_IDX_W'(1):  v = ZW'(1740967);
      ATAN_IDX_W'(2):  v = ZW'(919879);
      ATAN_IDX_W'(3):  v = ZW'(466945);
      ATAN_IDX_W'(4):  v = ZW'(234379);
      ATAN_IDX_W'(5):  v = ZW'(117304);
      ATAN_IDX_W'(6):  v = ZW'(58666);
      ATAN_IDX_W'(7):  v = ZW'(29335);
      ATAN_IDX_W'(8):  v = ZW'(14668);
      ATAN_IDX_W'(9):  v = ZW'(7334);
      ATAN_IDX_W'(10): v = ZW'(3667);
      ATAN_IDX_W'(11): v = ZW'(1833);
      ATAN_IDX_W'(12): v = ZW'(917);
      ATAN_IDX_W'(13): v = ZW'(458);
      ATAN_IDX_W'(14): v = ZW'(229);
      ATAN_IDX_W'(15): v = ZW'(115);
      ATAN_IDX_W'(16): v = ZW'(57);
      ATAN_IDX_W'(17): v = ZW'(29);
      ATAN_IDX_W'(18): v = ZW'(14);
      ATAN_IDX_W'(19): v = ZW'(7);
      ATAN_IDX_W'(20): v = ZW'(4);
      ATAN_IDX_W'(21): v = ZW'(2);
      ATAN_IDX_W'(22): v = ZW'(1);
      default:         v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/c2p_prep.sv @@
// Front end: input register, squares, quadrant pre-rotation and sum of squares.
// Three register stages. Depends on c2p_pkg.
module c2p_prep import c2p_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic signed [COORD_W-1:0] x_coord_i,
  input  logic signed [COORD_W-1:0] y_coord_i,
  output logic                      valid_o,
  output c2p_flags_t                flags_o,
  output c2p_vec_t                  vec_o,
  output logic [SQ_W-1:0]           sum_sq_o
);

  logic                      v1_q, v2_q, v3_q;
  logic signed [COORD_W-1:0] x1_q, y1_q;
  logic [SQ_W-1:0]           sqx_q, sqy_q, sum_q;
  c2p_vec_t                  vec2_q, vec3_q, vec2_d;
  c2p_flags_t                flags2_q, flags3_q, flags2_d;

  logic signed [2*COORD_W-1:0] px, py;
  logic signed [ROT_W-1:0]     xe, ye, xr, yr;
  logic signed [ZW-1:0]        zr;
  logic signed [CW-1:0]        xw, yw;

  assign px = x1_q * x1_q;
  assign py = y1_q * y1_q;
  assign xe = ROT_W'(x1_q);
  assign ye = ROT_W'(y1_q);

  always_comb begin
    xr = xe;
    yr = ye;
    zr = '0;
    if (xe < 0) begin
      if (ye > 0) begin
        xr = ye;
        yr = -xe;
        zr = DEG90_FIX;
      end else begin
        xr = -ye;
        yr = xe;
        zr = -DEG90_FIX;
      end
    end
    xw = CW'(xr) <<< FRAC_SHIFT;
    yw = CW'(yr) <<< FRAC_SHIFT;
    vec2_d.x = xw;
    vec2_d.y = yw;
    vec2_d.z = zr;
    flags2_d.y_zero = (y1_q == '0);
    flags2_d.x_neg  = x1_q[COORD_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q     <= x_coord_i;
    y1_q     <= y_coord_i;
    sqx_q    <= SQ_W'($unsigned(px));
    sqy_q    <= SQ_W'($unsigned(py));
    vec2_q   <= vec2_d;
    flags2_q <= flags2_d;
    sum_q    <= sqx_q + sqy_q;
    vec3_q   <= vec2_q;
    flags3_q <= flags2_q;
  end

  assign valid_o  = v3_q;
  assign flags_o  = flags3_q;
  assign vec_o    = vec3_q;
  assign sum_sq_o = sum_q;

endmodule

@@ sv/c2p_cordic.sv @@
// Vectoring CORDIC pipeline: one micro-rotation per register stage.
// Carries the valid bit and special-case flags alongside. Depends on c2p_pkg.
module c2p_cordic import c2p_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  c2p_flags_t flags_i,
  input  c2p_vec_t   vec_i,
  output logic       valid_o,
  output c2p_flags_t flags_o,
  output logic signed [ZW-1:0] z_o
);

  logic       valid_q [PIPE_STEPS];
  c2p_flags_t flags_q [PIPE_STEPS];
  c2p_vec_t   vec_q   [PIPE_STEPS];

  for (genvar i = 0; i < PIPE_STEPS; i++) begin : g_stage
    c2p_vec_t   vin, vec_d;
    c2p_flags_t fin;
    logic       vld;

    if (i == 0) begin : g_first
      assign vin = vec_i;
      assign fin = flags_i;
      assign vld = valid_i;
    end else begin : g_next
      assign vin = vec_q[i-1];
      assign fin = flags_q[i-1];
      assign vld = valid_q[i-1];
    end

    if (i < CORDIC_ITER) begin : g_rot
      logic signed [CW-1:0] dx, dy;
      logic signed [ZW-1:0] da;
      assign dx = $signed(vin.y) >>> i;
      assign dy = $signed(vin.x) >>> i;
      assign da = atan_lut(ATAN_IDX_W'(i));
      always_comb begin
        if (vin.y[CW-1]) begin
          vec_d.x = vin.x - dx;
          vec_d.y = vin.y + dy;
          vec_d.z = vin.z - da;
        end else begin
          vec_d.x = vin.x + dx;
          vec_d.y = vin.y - dy;
          vec_d.z = vin.z + da;
        end
      end
    end else begin : g_pass
      assign vec_d = vin;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else begin
        valid_q[i] <= vld;
      end
    end

    always_ff @(posedge clk_i) begin
      vec_q[i]   <= vec_d;
      flags_q[i] <= fin;
    end
  end

  assign valid_o = valid_q[PIPE_STEPS-1];
  assign flags_o = flags_q[PIPE_STEPS-1];
  assign z_o     = vec_q[PIPE_STEPS-1].z;

endmodule

@@ sv/c2p_isqrt.sv @@
// Restoring integer square root, one result bit per register stage.
// Same depth as the CORDIC pipeline. Depends on c2p_pkg.
module c2p_isqrt import c2p_pkg::*; (
  input  logic              clk_i,
  input  logic [SQ_W-1:0]   sum_sq_i,
  output logic [SQ_W-1:0]   rem_o,
  output logic [ROOT_W-1:0] root_o
);

  c2p_root_t rt_q [PIPE_STEPS];

  for (genvar j = 0; j < PIPE_STEPS; j++) begin : g_stage
    c2p_root_t rin, rt_d;

    if (j == 0) begin : g_first
      assign rin.rem  = sum_sq_i;
      assign rin.root = '0;
    end else begin : g_next
      assign rin = rt_q[j-1];
    end

    if (j < SQRT_STEPS) begin : g_bit
      localparam int K = SQRT_STEPS - 1 - j;
      logic [SQ_TW-1:0] trial, rem_w;
      logic             take;
      assign trial = (SQ_TW'(rin.root) << (K + 1)) + (SQ_TW'(1) << (2 * K));
      assign rem_w = SQ_TW'(rin.rem);
      assign take  = (rem_w >= trial);
      assign rt_d.rem  = take ? SQ_W'(rem_w - trial) : rin.rem;
      assign rt_d.root = take ? (rin.root | (ROOT_W'(1) << K)) : rin.root;
    end else begin : g_pass
      assign rt_d = rin;
    end

    always_ff @(posedge clk_i) begin
      rt_q[j] <= rt_d;
    end
  end

  assign rem_o  = rt_q[PIPE_STEPS-1].rem;
  assign root_o = rt_q[PIPE_STEPS-1].root;

endmodule

@@ sv/c2p_post.sv @@
// Output stage: angle rounding and saturation, axis cases, radius rounding.
// One register stage. Depends on c2p_pkg.
module c2p_post import c2p_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  c2p_flags_t                flags_i,
  input  logic signed [ZW-1:0]      z_i,
  input  logic [SQ_W-1:0]           rem_i,
  input  logic [ROOT_W-1:0]         root_i,
  output logic                      done_o,
  output logic [RADIUS_W-1:0]       radius_o,
  output logic signed [ANGLE_W-1:0] angle_o
);

  logic                      done_q;
  logic [RADIUS_W-1:0]       radius_q, radius_d;
  logic signed [ANGLE_W-1:0] angle_q, angle_d;
  logic signed [ZW-1:0]      zsum, zr, zsat;

  assign zsum = z_i + ANGLE_RND;
  assign zr   = zsum >>> ANGLE_SHIFT;

  always_comb begin
    if (zr > ANGLE_MAX) begin
      zsat = ANGLE_MAX;
    end else if (zr < -ANGLE_MAX) begin
      zsat = -ANGLE_MAX;
    end else begin
      zsat = zr;
    end
    if (flags_i.y_zero) begin
      angle_d = flags_i.x_neg ? ANGLE_LIM : '0;
    end else begin
      angle_d = ANGLE_W'(zsat);
    end
    radius_d = (rem_i > SQ_W'(root_i)) ? RADIUS_W'(root_i + ROOT_W'(1)) : RADIUS_W'(root_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    radius_q <= radius_d;
    angle_q  <= angle_d;
  end

  assign done_o   = done_q;
  assign radius_o = radius_q;
  assign angle_o  = angle_q;

endmodule

@@ sv/cartesian_to_polar.sv @@
// Top level of the cartesian-to-polar converter: prep, CORDIC, square root, output.
// Depends on c2p_pkg, c2p_prep, c2p_cordic, c2p_isqrt, c2p_post.
//
//   channel  | handshake            | words
//   ---------+----------------------+-----------------------------------
//   point in | start_i / busy_o     | x_coord_i, y_coord_i (Q8.8 signed)
//   polar out| done_o (1-cycle)     | radius_out_o (Q8.8), angle_deg_o (deg Q9.8)
//
// One word per clock; busy_o never rises, since nothing in the pipe waits.
// Words pass through the prep registers, then the CORDIC and square-root pipelines
// running side by side, one step per stage, then the output register.
// Reset clears the valid bits only; data registers hold whatever they had.
// The receiver cannot stall: done_o lasts one cycle per word.
module cartesian_to_polar import c2p_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic signed [COORD_W-1:0] x_coord_i,
  input  logic signed [COORD_W-1:0] y_coord_i,
  output logic                      done_o,
  output logic [RADIUS_W-1:0]       radius_out_o,
  output logic signed [ANGLE_W-1:0] angle_deg_o
);

  logic              accept;
  logic              p_valid, c_valid;
  c2p_flags_t        p_flags, c_flags;
  c2p_vec_t          p_vec;
  logic [SQ_W-1:0]   p_sum, s_rem;
  logic [ROOT_W-1:0] s_root;
  logic signed [ZW-1:0] c_z;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  c2p_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (accept),
    .x_coord_i (x_coord_i),
    .y_coord_i (y_coord_i),
    .valid_o   (p_valid),
    .flags_o   (p_flags),
    .vec_o     (p_vec),
    .sum_sq_o  (p_sum)
  );

  c2p_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p_valid),
    .flags_i (p_flags),
    .vec_i   (p_vec),
    .valid_o (c_valid),
    .flags_o (c_flags),
    .z_o     (c_z)
  );

  c2p_isqrt u_isqrt (
    .clk_i    (clk_i),
    .sum_sq_i (p_sum),
    .rem_o    (s_rem),
    .root_o   (s_root)
  );

  c2p_post u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (c_valid),
    .flags_i  (c_flags),
    .z_i      (c_z),
    .rem_i    (s_rem),
    .root_i   (s_root),
    .done_o   (done_o),
    .radius_o (radius_out_o),
    .angle_o  (angle_deg_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("accepted word did not come out after the pipeline latency");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("done without a matching accepted word");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (angle_deg_o <= ANGLE_LIM && angle_deg_o >= -ANGLE_LIM))
    else $error("angle outside +-180 degrees");

  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && x_coord_i == '0 && y_coord_i == '0)
      |-> ##LATENCY (radius_out_o == '0 && angle_deg_o == '0))
    else $error("origin did not map to zero radius and angle");

endmodule
